>>> src/nsdr_pkg.sv
// Package for the n-step discounted return block: entry layout, microcode format and program.
package nsdr_pkg;

  // Q1.16 representation of 1.0, also the gamma ceiling.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Rounding constant for the Q32 to Q16 conversions.
  localparam int unsigned HALF_Q16 = 32768;

  // Configuration register indexes.
  localparam logic CFG_GAMMA       = 1'b0;
  localparam logic CFG_STEP_RETURN = 1'b1;

  // One window entry.
  typedef struct packed {
    logic               done;
    logic signed [31:0] reward;
    logic [7:0]         act;
    logic [15:0]        tag;
  } entry_t;

  // Program steps; the step counter walks these.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_BOOT,
    ST_BACC,
    ST_RND,
    ST_SAT
  } step_t;

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    OP_PUSH,
    OP_START,
    OP_READ,
    OP_MUL,
    OP_ACC_T,
    OP_BOOT,
    OP_ACC,
    OP_RND,
    OP_EMIT
  } op_t;

  // Sequencing rule of a control word.
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_IF_MORE,
    JMP_IF_NONE,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    op_t   op;
    jmp_t  jmp;
    step_t target;
  } ctrl_t;

  // Control store.
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    unique case (pc)
      ST_IDLE:  w = '{op: OP_PUSH,  jmp: JMP_WAIT_IN,  target: ST_CHECK};
      ST_CHECK: w = '{op: OP_START, jmp: JMP_IF_NONE,  target: ST_IDLE};
      ST_RD:    w = '{op: OP_READ,  jmp: JMP_NEXT,     target: ST_IDLE};
      ST_MUL:   w = '{op: OP_MUL,   jmp: JMP_NEXT,     target: ST_IDLE};
      ST_ACC:   w = '{op: OP_ACC_T, jmp: JMP_IF_MORE,  target: ST_RD};
      ST_BOOT:  w = '{op: OP_BOOT,  jmp: JMP_NEXT,     target: ST_IDLE};
      ST_BACC:  w = '{op: OP_ACC,   jmp: JMP_NEXT,     target: ST_IDLE};
      ST_RND:   w = '{op: OP_RND,   jmp: JMP_NEXT,     target: ST_IDLE};
      ST_SAT:   w = '{op: OP_EMIT,  jmp: JMP_WAIT_OUT, target: ST_CHECK};
      default:  w = '{op: OP_PUSH,  jmp: JMP_WAIT_IN,  target: ST_CHECK};
    endcase
    return w;
  endfunction

endpackage

>>> src/n_step_discounted_return.sv
// Top level of the n-step discounted return block: window memory, microcoded sequencer, datapath.
// An accepted beat reaches the check step in the next cycle; each result then runs through
//   check, n read/multiply/accumulate triplets, bootstrap pair, round and saturate, with
//   n = min(step_return, window count). A beat causing no result goes from the check step
//   back to idle and frees the input. One beat is worked on at a time.
// The per-term triplet is set by the registered window memory read and the registered multiply step.
// Reset (rst_n low, synchronous): window empty, gamma 64881, step_return 5; memory not cleared.
module n_step_discounted_return #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats.
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata fields, lowest bit up: state_tag[15:0], action[23:16], reward[55:24],
  // bootstrap_value[87:56].
  input  logic [87:0] in_tdata,
  // in_tlast carries done_req.
  input  logic        in_tlast,
  // Result beats.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata fields, lowest bit up: out_state_tag[15:0], out_action[23:16],
  // discounted_return[55:24].
  output logic [55:0] out_tdata,
  // out_tlast carries last.
  output logic        out_tlast,
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  // Products are 50 bits signed; up to WINDOW_DEPTH + 1 of them are summed.
  localparam int ACC_W = 50 + $clog2(WINDOW_DEPTH + 2);
  localparam int RND_W = ACC_W - 16;

  // Configuration registers.
  logic [16:0] gamma_r;
  logic [3:0]  sr_r;

  // Sequencer.
  nsdr_pkg::step_t pc_r, pc_nxt;
  nsdr_pkg::ctrl_t ctrl;

  // Window bookkeeping.
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Per-beat values kept while its results are worked out.
  logic               done_r, done_nxt;
  logic signed [31:0] boot_r, boot_nxt;

  // Return datapath.
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]         t_r, t_nxt;
  logic [PTR_W-1:0]         ptr_r, ptr_nxt;
  logic [16:0]              g_r, g_nxt;
  logic [33:0]              gprod_r, gprod_nxt;
  logic signed [49:0]       prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [RND_W-1:0]  rnd_r, rnd_nxt;
  logic                     last_done_r, last_done_nxt;
  logic [15:0]              hd_tag_r, hd_tag_nxt;
  logic [7:0]               hd_act_r, hd_act_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [55:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  // Window memory.
  nsdr_pkg::entry_t mem [WINDOW_DEPTH];
  nsdr_pkg::entry_t rdata_r;
  nsdr_pkg::entry_t wentry;
  logic [PTR_W-1:0] waddr;
  logic [CNT_W:0]   wsum;
  logic             mem_we;
  logic             mem_re;

  // Decoded conditions.
  logic             accept;
  logic             out_free;
  logic             emit_go;
  logic             work;
  logic             more;
  logic [CNT_W-1:0] sr_eff;
  logic [16:0]      gm;
  logic [CNT_W-1:0] count_dec;
  logic [ACC_W-1:0] acc_round;
  logic [RND_W-32:0] rnd_top;
  logic [31:0]      sat_val;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign ctrl      = nsdr_pkg::ucode(pc_r);
  assign in_tready = (ctrl.op == nsdr_pkg::OP_PUSH);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign emit_go   = (ctrl.op == nsdr_pkg::OP_EMIT) && out_free;

  // Step return clamped to 1..WINDOW_DEPTH, gamma clamped to 1.0.
  always_comb begin
    if (sr_r == 4'd0) begin
      sr_eff = CNT_W'(1);
    end else if (int'(sr_r) > WINDOW_DEPTH) begin
      sr_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      sr_eff = CNT_W'(sr_r);
    end
  end

  assign gm = (gamma_r > nsdr_pkg::ONE_Q16) ? nsdr_pkg::ONE_Q16 : gamma_r;

  // The oldest entry is emitted while the window is full enough, or drained at episode end.
  assign work      = (count_r != '0) && ((count_r >= sr_eff) || done_r);
  assign more      = (CNT_W'(t_r + 1'b1) < n_r);
  assign count_dec = CNT_W'(count_r - 1'b1);

  // Append position: head + count, wrapped once. A full window overwrites its oldest entry.
  always_comb begin
    wsum = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(count_r);
    if (count_r == CNT_W'(WINDOW_DEPTH)) begin
      waddr = head_r;
    end else if (wsum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
      waddr = PTR_W'(wsum - (CNT_W + 1)'(WINDOW_DEPTH));
    end else begin
      waddr = PTR_W'(wsum);
    end
  end

  assign wentry.tag    = in_tdata[15:0];
  assign wentry.act    = in_tdata[23:16];
  assign wentry.reward = in_tdata[55:24];
  assign wentry.done   = in_tlast;
  assign mem_we        = accept;
  assign mem_re        = (ctrl.op == nsdr_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wentry;
    end
    if (mem_re) begin
      rdata_r <= mem[ptr_r];
    end
  end

  // Rounding and saturation of the accumulated sum.
  assign acc_round = acc_r + ACC_W'(nsdr_pkg::HALF_Q16);
  assign rnd_top   = rnd_r[RND_W-1:31];
  always_comb begin
    if ((&rnd_top) || !(|rnd_top)) begin
      sat_val = rnd_r[31:0];
    end else if (rnd_r[RND_W-1]) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = 32'h7FFF_FFFF;
    end
  end

  // Next step.
  always_comb begin
    unique case (ctrl.jmp)
      nsdr_pkg::JMP_NEXT:     pc_nxt = nsdr_pkg::step_t'(pc_r + 4'd1);
      nsdr_pkg::JMP_IF_MORE:  pc_nxt = more ? ctrl.target : nsdr_pkg::step_t'(pc_r + 4'd1);
      nsdr_pkg::JMP_IF_NONE:  pc_nxt = work ? nsdr_pkg::step_t'(pc_r + 4'd1) : ctrl.target;
      nsdr_pkg::JMP_WAIT_IN:  pc_nxt = accept ? ctrl.target : pc_r;
      nsdr_pkg::JMP_WAIT_OUT: pc_nxt = out_free ? ctrl.target : pc_r;
      default:                pc_nxt = nsdr_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls decoded from the control word.
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    boot_nxt      = boot_r;
    n_nxt         = n_r;
    t_nxt         = t_r;
    ptr_nxt       = ptr_r;
    g_nxt         = g_r;
    gprod_nxt     = gprod_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    rnd_nxt       = rnd_r;
    last_done_nxt = last_done_r;
    hd_tag_nxt    = hd_tag_r;
    hd_act_nxt    = hd_act_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (ctrl.op)
      nsdr_pkg::OP_PUSH: begin
        if (accept) begin
          done_nxt = in_tlast;
          boot_nxt = in_tdata[87:56];
          if (count_r == CNT_W'(WINDOW_DEPTH)) begin
            head_nxt = ptr_inc(head_r);
          end else begin
            count_nxt = CNT_W'(count_r + 1'b1);
          end
        end
      end
      nsdr_pkg::OP_START: begin
        n_nxt   = (count_r < sr_eff) ? count_r : sr_eff;
        t_nxt   = '0;
        ptr_nxt = head_r;
        g_nxt   = nsdr_pkg::ONE_Q16;
        acc_nxt = '0;
      end
      nsdr_pkg::OP_READ: begin
      end
      nsdr_pkg::OP_MUL: begin
        prod_nxt      = rdata_r.reward * $signed({1'b0, g_r});
        gprod_nxt     = g_r * gm;
        last_done_nxt = rdata_r.done;
        if (t_r == '0) begin
          hd_tag_nxt = rdata_r.tag;
          hd_act_nxt = rdata_r.act;
        end
      end
      nsdr_pkg::OP_ACC_T: begin
        acc_nxt = acc_r + ACC_W'(prod_r);
        g_nxt   = 17'((gprod_r + 34'(nsdr_pkg::HALF_Q16)) >> 16);
        t_nxt   = CNT_W'(t_r + 1'b1);
        ptr_nxt = ptr_inc(ptr_r);
      end
      nsdr_pkg::OP_BOOT: begin
        // Bootstrap only when the last summed entry does not end the episode.
        if (last_done_r) begin
          prod_nxt = '0;
        end else begin
          prod_nxt = boot_r * $signed({1'b0, g_r});
        end
      end
      nsdr_pkg::OP_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
      nsdr_pkg::OP_RND: begin
        rnd_nxt = RND_W'($signed(acc_round) >>> 16);
      end
      nsdr_pkg::OP_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {sat_val, hd_act_r, hd_tag_r};
          // Last result of this beat when the window will no longer qualify after the pop.
          out_last_nxt  = !((count_dec != '0) && ((count_dec >= sr_eff) || done_r));
          head_nxt      = ptr_inc(head_r);
          count_nxt     = count_dec;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= nsdr_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      gamma_r     <= 17'd64881;
      sr_r        <= 4'd5;
    end else begin
      pc_r        <= pc_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          nsdr_pkg::CFG_GAMMA:       gamma_r <= cfg_wdata;
          nsdr_pkg::CFG_STEP_RETURN: sr_r    <= cfg_wdata[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    done_r      <= done_nxt;
    boot_r      <= boot_nxt;
    n_r         <= n_nxt;
    t_r         <= t_nxt;
    ptr_r       <= ptr_nxt;
    g_r         <= g_nxt;
    gprod_r     <= gprod_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    rnd_r       <= rnd_nxt;
    last_done_r <= last_done_nxt;
    hd_tag_r    <= hd_tag_nxt;
    hd_act_r    <= hd_act_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The window never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window count above depth");

  // A result is never taken from an empty window.
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> (count_r != '0))
    else $error("pop from empty window");

  // Every multiply step works on a term inside the summed range.
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == nsdr_pkg::ST_MUL) |-> ((n_r != '0) && (t_r < n_r)))
    else $error("term index outside summed range");

  // An accepted beat is always checked for work in the next cycle.
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (pc_r == nsdr_pkg::ST_CHECK))
    else $error("accepted beat not checked");

  // The discount power never exceeds 1.0 while a return is being built.
  a_gamma_pow: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == nsdr_pkg::ST_MUL || pc_r == nsdr_pkg::ST_BOOT) |-> (g_r <= nsdr_pkg::ONE_Q16))
    else $error("discount power above one");

endmodule

>>> dv/nsdr_result_checker.sv
`timescale 1ns / 1ps
// Checker for the n-step discounted return block: window predictor and per-beat result comparison.
module nsdr_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // in_tdata fields, lowest bit up: state_tag, action, reward, bootstrap_value.
  input  logic [87:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata fields, lowest bit up: out_state_tag, out_action, discounted_return.
  input  logic [55:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata,
  output int          mismatches,
  output int          pending_results
);

  localparam int          DEPTH          = 8;
  localparam logic [16:0] GAMMA_AT_RESET = 17'd64881;
  localparam logic [3:0]  STEPS_AT_RESET = 4'd5;
  localparam longint      RET_MAX        = 2147483647;
  localparam longint      RET_MIN        = -RET_MAX - 1;

  // One result beat, laid out as {out_tlast, out_tdata}.
  typedef struct packed {
    logic               last;
    logic signed [31:0] ret;
    logic [7:0]         act;
    logic [15:0]        tag;
  } return_beat_t;

  nsdr_pkg::entry_t window [DEPTH];
  logic [2:0]       head;
  logic [3:0]       fill;
  logic [16:0]      gamma_q;
  logic [3:0]       steps_q;
  return_beat_t     expected_returns [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Sum of gamma^t * reward over the n oldest entries, plus the bootstrap term when
  // entry n-1 does not end the episode; rounded half up to Q16.16 and saturated.
  function automatic logic signed [31:0] discounted_sum(input logic [3:0] n,
                                                        input logic signed [31:0] boot);
    longint     acc;
    longint     weight;
    longint     g_eff;
    longint     rounded;
    logic [2:0] slot;
    g_eff  = (gamma_q > nsdr_pkg::ONE_Q16) ? longint'(nsdr_pkg::ONE_Q16) : longint'(gamma_q);
    weight = longint'(nsdr_pkg::ONE_Q16);
    acc    = 0;
    for (int t = 0; t < n; t++) begin
      slot   = head + 3'(t);
      acc   += longint'(window[slot].reward) * weight;
      weight = (weight * g_eff + longint'(nsdr_pkg::HALF_Q16)) >>> 16;
    end
    slot = head + 3'(n - 1'b1);
    if (!window[slot].done) acc += longint'(boot) * weight;
    rounded = (acc + longint'(nsdr_pkg::HALF_Q16)) >>> 16;
    if (rounded > RET_MAX) rounded = RET_MAX;
    if (rounded < RET_MIN) rounded = RET_MIN;
    return rounded[31:0];
  endfunction

  // Push one step into the window and queue every return it releases, oldest first.
  task automatic predict_returns(input logic [87:0] beat, input logic done);
    logic [3:0]         span;
    logic [3:0]         n;
    logic [2:0]         slot;
    logic signed [31:0] boot;
    return_beat_t       r;
    int                 emitted;
    span    = (steps_q == 4'd0) ? 4'd1 : (steps_q > DEPTH) ? 4'(DEPTH) : steps_q;
    boot    = beat[87:56];
    emitted = 0;
    if (fill >= DEPTH) begin
      head = head + 1'b1;
      fill = fill - 1'b1;
    end
    slot = head + fill[2:0];
    window[slot] = '{done: done, reward: beat[55:24], act: beat[23:16], tag: beat[15:0]};
    fill = fill + 1'b1;
    while (fill != 4'd0 && (fill >= span || done)) begin
      n      = (fill < span) ? fill : span;
      r.tag  = window[head].tag;
      r.act  = window[head].act;
      r.ret  = discounted_sum(n, boot);
      r.last = 1'b0;
      expected_returns.insert(expected_returns.size(), r);
      head = head + 1'b1;
      fill = fill - 1'b1;
      emitted++;
    end
    if (emitted > 0) begin
      expected_returns[expected_returns.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_return(input return_beat_t got);
    return_beat_t want;
    if (expected_returns.size() == 0) begin
      report_mismatch("result beat with nothing expected, tag", 32'(got.tag), '0);
    end else begin
      want = expected_returns[0];
      expected_returns.delete(0);
      if (got.tag !== want.tag) report_mismatch("state tag", 32'(got.tag), 32'(want.tag));
      if (got.act !== want.act) report_mismatch("action", 32'(got.act), 32'(want.act));
      if (got.ret !== want.ret) report_mismatch("discounted return", got.ret, want.ret);
      if (got.last !== want.last) report_mismatch("last flag", 32'(got.last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head    = '0;
      fill    = '0;
      gamma_q = GAMMA_AT_RESET;
      steps_q = STEPS_AT_RESET;
      expected_returns.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == nsdr_pkg::CFG_GAMMA) gamma_q = cfg_wdata;
        else if (cfg_addr == nsdr_pkg::CFG_STEP_RETURN) steps_q = cfg_wdata[3:0];
      end
      // A result leaving at this edge can never belong to a step entering at it.
      if (out_tvalid && out_tready) check_return(return_beat_t'({out_tlast, out_tdata}));
      if (in_tvalid && in_tready) predict_returns(in_tdata, in_tlast);
    end
    pending_results = expected_returns.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the n-step discounted return block: stimulus, flow control and verdict.
module testbench;

  // The timeout is far above the slowest correct run: roughly 270 steps, each result
  // costing at most a full eight-entry return of work plus random stalls, one long
  // hold-off and the settling pauses between configuration changes.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;
  // A step that releases no return still occupies the block through its check step,
  // and a full eight-entry return runs through every step; this pause covers both with margin.
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_SETS   = 8;
  localparam int STEPS_PER_SET = 31;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // in_tdata fields, lowest bit up: state_tag[15:0], action[23:16], reward[55:24],
  // bootstrap_value[87:56].
  logic [87:0] in_tdata  = '0;
  // in_tlast carries done_req.
  logic        in_tlast  = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_tdata fields, lowest bit up: out_state_tag[15:0], out_action[23:16],
  // discounted_return[55:24].
  logic [55:0] out_tdata;
  // out_tlast carries last.
  logic        out_tlast;
  logic        cfg_we    = 1'b0;
  logic        cfg_addr  = nsdr_pkg::CFG_GAMMA;
  logic [16:0] cfg_wdata = '0;

  int          mismatches;
  int          pending_results;

  // Flow-control knobs: percent of cycles the sender stays idle and the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // The stimulus process bumps hold_asks; the receiver process owns the hold countdown.
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycle_count = 0;

  // Idle mixes, one per pair of random sets: {sender idle, receiver stall}.
  int unsigned idle_table [4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{32, 32}};

  always #2 clk = ~clk;

  n_step_discounted_return u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  nsdr_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  // Receiver: random back-pressure, or a long hold-off when one is requested. The hold
  // lets the sender keep offering steps until the block stalls its input.
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog. A missing or stuck result beat ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one step beat, after a random number of idle cycles, and return at the edge
  // where it is taken. Valid stays high so the next beat can follow without a gap.
  task automatic send_step(input logic [15:0] tag, input logic [7:0] act,
                           input logic [31:0] reward, input logic done,
                           input logic [31:0] boot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {boot, reward, act, tag};
    in_tlast  <= done;
    do @(posedge clk); while (!in_tready);
  endtask

  // Rewards and bootstrap values are mostly modest so sums stay meaningful, with a
  // quarter of them drawn over the full 32-bit range to hit saturation and every bit.
  task automatic send_random_step();
    logic [31:0] reward;
    logic [31:0] boot;
    reward = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2097151) - 32'd1048576;
    boot   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2097151) - 32'd1048576;
    // Roughly one step in six ends an episode, so windows both fill and flush.
    send_step(16'($urandom), 8'($urandom), reward, $urandom_range(5) == 0, boot);
  endtask

  // Stop offering, wait until every expected result beat has arrived, then give the
  // block time to finish any step that releases nothing.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are rewritten every time; only called while the block is idle.
  task automatic set_config(input logic [16:0] gamma, input logic [3:0] steps);
    cfg_we    <= 1'b1;
    cfg_addr  <= nsdr_pkg::CFG_GAMMA;
    cfg_wdata <= gamma;
    @(posedge clk);
    cfg_addr  <= nsdr_pkg::CFG_STEP_RETURN;
    cfg_wdata <= {13'd0, steps};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Gamma settings lean on realistic discounts near one but keep zero, exactly one
  // and the above-one range (which the block clamps) in the mix.
  function automatic logic [16:0] random_gamma();
    case ($urandom_range(5))
      0:       return 17'd0;
      1:       return nsdr_pkg::ONE_Q16;
      2:       return 17'h1FFFF;
      3:       return 17'($urandom_range(131071));
      default: return 17'($urandom_range(65535, 55000));
    endcase
  endfunction

  // Mostly legal step counts; a quarter of the time anything the 4-bit register holds,
  // including zero and values beyond the window depth.
  function automatic logic [3:0] random_steps();
    if ($urandom_range(3) == 0) return 4'($urandom_range(15));
    return 4'($urandom_range(8, 1));
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings (gamma 64881, five steps): four steps release nothing, the fifth
    // ends the episode and flushes all five. Field extremes ride along.
    send_step(16'h0000, 8'h00, 32'h7FFF_FFFF, 1'b0, 32'h8000_0000);
    send_step(16'hFFFF, 8'hFF, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF);
    send_step(16'h1234, 8'h5A, 32'h0001_0000, 1'b0, 32'h0000_8000);
    send_step(16'hA5A5, 8'hC3, 32'hFFFF_0000, 1'b0, 32'h0000_0000);
    send_step(16'h5A5A, 8'h3C, 32'h0000_0001, 1'b1, 32'h1234_5678);

    // Gamma of exactly one over the full eight-step window: the eighth step releases
    // one return that saturates high, leaving seven entries behind.
    wait_idle();
    set_config(nsdr_pkg::ONE_Q16, 4'd8);
    repeat (8) send_step(16'($urandom), 8'($urandom), 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF);

    // Lowered step count with gamma above one: the next step releases all eight
    // waiting entries at once, the last of them saturating low.
    wait_idle();
    set_config(17'h1FFFF, 4'd1);
    send_step(16'hBEEF, 8'h81, 32'h8000_0000, 1'b0, 32'h8000_0000);

    // A step count of zero behaves as one; gamma zero drops everything past the
    // first term, including the bootstrap.
    wait_idle();
    set_config(17'd0, 4'd0);
    send_step(16'h0F0F, 8'h0F, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
    send_step(16'hF0F0, 8'hF0, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF);

    // A step count above the window depth behaves as the full depth; an episode end
    // after four steps flushes a short window.
    wait_idle();
    set_config(17'hFFFF, 4'hF);
    repeat (3) send_step(16'($urandom), 8'($urandom), 32'h8000_0000, 1'b0, 32'h8000_0000);
    send_step(16'h7E57, 8'h42, 32'h8000_0000, 1'b1, 32'h8000_0000);

    // Random sets: each idle mix gets two configurations. The first set also asks
    // the receiver for one long hold-off while the sender never pauses.
    for (int set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
      wait_idle();
      set_config(random_gamma(), random_steps());
      send_idle_pct  = idle_table[set_idx / 2][0];
      recv_stall_pct <= idle_table[set_idx / 2][1];
      if (set_idx == 0) hold_asks <= hold_asks + 1;
      repeat (STEPS_PER_SET) send_random_step();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
